[rtl/animation_delta_bitstream_decoder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the animation delta bitstream decoder
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ANIMATION_DELTA_BITSTREAM_DECODER_ASSERT_SVH
`define ANIMATION_DELTA_BITSTREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that an implication holds at every clock edge out of reset.
`define ADB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an expression never goes high out of reset.
`define ADB_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ADB_ASSERT(label, clk, rst_n, prop, msg)
`define ADB_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/adbd_pkg.sv]
// ---------------------------------------------------------------------------
// adbd_pkg
// Shared types and constants of the animation delta bitstream decoder.
// ---------------------------------------------------------------------------
package adbd_pkg;

    localparam int MAX_BONES_DEF = 64;
    localparam int BONE_W        = 6;
    localparam int FRAME_W       = 16;
    localparam int VALUE_W       = 17;
    localparam int PEND_W        = 24;
    localparam int CNT_W         = 5;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_RES       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BONES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREC_KEY = 2'd2;

    localparam logic [0:0] CMD_DATA  = 1'b0;
    localparam logic [0:0] CMD_BEGIN = 1'b1;

    // decode phases of the bitstream
    typedef enum logic [2:0] {
        PH_FIRST_OFS = 3'd0,
        PH_FIRST_ROT = 3'd1,
        PH_DELTA_OFS = 3'd2,
        PH_DELTA_ROT = 3'd3,
        PH_DONE      = 3'd4
    } phase_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear;      // begin command: clear position and pending bits
        logic drop;       // finished: drop pending bits
        logic load;       // append an incoming byte
        logic try_dec;    // evaluate one value this cycle
        logic acc_rd;     // read accumulator for current position
        logic commit;     // consume the decoded value, write it out
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic ok;         // enough bits for a value
        logic done;       // animation finished
    } dp_sts_t;

endpackage

[rtl/adbd_ctrl.sv]
// ---------------------------------------------------------------------------
// adbd_ctrl
// Sequencer: takes a request, runs the value decode loop, hands results out.
// ---------------------------------------------------------------------------
module adbd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  logic              in_hold,
    input  logic              res_free,
    output adbd_pkg::dp_cmd_t cmd,
    input  adbd_pkg::dp_sts_t sts,
    output logic              idle
);
    import adbd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TRY  = 5'b00010,
        S_READ = 5'b00100,
        S_EMIT = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      nres_reg, nres_next;
    logic            take;

    // hold off new requests while the last result of a byte is held back
    assign idle     = (state_reg == S_IDLE);
    assign in_ready = idle && !in_hold;
    assign take     = in_valid && in_ready;

    // sequence one request: begin, drop, or one byte's worth of values
    always_comb
    begin
        state_next = state_reg;
        nres_next  = nres_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_cmd == CMD_BEGIN)
                        cmd.clear = 1'b1;
                    else if (sts.done)
                        cmd.drop = 1'b1;
                    else
                    begin
                        cmd.load   = 1'b1;
                        nres_next  = 4'd0;
                        state_next = S_TRY;
                    end
                end
            end
            S_TRY:
            begin
                cmd.try_dec = 1'b1;
                if (nres_reg == 4'(MAX_RES))
                    state_next = S_IDLE;
                else if (sts.done)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!sts.ok)
                    state_next = S_IDLE;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.acc_rd = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    cmd.commit = 1'b1;
                    nres_next  = nres_reg + 4'd1;
                    state_next = S_TRY;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nres_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            nres_reg  <= nres_next;
        end
    end

    `include "animation_delta_bitstream_decoder_assert.svh"
    `ADB_NEVER(a_emit_cap, clk, rst_n, state_reg == S_EMIT && nres_reg >= 4'(MAX_RES), "over eight results")
    `ADB_ASSERT(a_commit_try, clk, rst_n, cmd.commit |=> state_reg == S_TRY, "commit not followed by try")
    `ADB_ASSERT(a_read_emit, clk, rst_n, state_reg == S_READ |=> state_reg == S_EMIT, "read without emit")

endmodule

[rtl/adbd_dp.sv]
// ---------------------------------------------------------------------------
// adbd_dp
// Datapath: bit buffer, value decode, position counters, accumulators.
// ---------------------------------------------------------------------------
module adbd_dp #(
    parameter int MAX_BONES = adbd_pkg::MAX_BONES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [6:0]                    num_bones,
    input  logic [15:0]                   num_frames,
    input  logic [3:0]                    precision_key,
    input  logic [7:0]                    data_byte,
    input  adbd_pkg::dp_cmd_t             cmd,
    output adbd_pkg::dp_sts_t             sts,
    output logic                          o_kind,
    output logic [adbd_pkg::FRAME_W-1:0]  o_frame,
    output logic [adbd_pkg::BONE_W-1:0]   o_bone,
    output logic [1:0]                    o_axis,
    output logic [adbd_pkg::VALUE_W-1:0]  o_value,
    output logic                          o_last_anim
);
    import adbd_pkg::*;

    localparam int DEPTH = 3 * MAX_BONES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BONES + 1);

    logic [PEND_W-1:0] bits_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [BW-1:0]     bone_reg;
    logic [1:0]        axis_reg;
    phase_t            phase_reg;
    logic [15:0]       mem [DEPTH];
    logic [15:0]       acc_reg;
    logic [16:0]       val_reg;
    logic [CNT_W-1:0]  len_reg;

    logic [3:0]        k;
    logic [3:0]        w;
    logic [BW-1:0]     nb;
    logic [PEND_W-1:0] al;
    logic              ok;
    logic [CNT_W-1:0]  len;
    logic signed [16:0] val;
    logic [2:0]        code;
    logic [AW-1:0]     idx;
    logic [15:0]       acc_new;
    logic signed [16:0] acc_s;
    logic              is_rot;
    logic              dn;

    assign k  = (precision_key > 4'd11) ? 4'd11 : precision_key;
    assign w  = 4'd12 - k;
    assign nb = (int'(num_bones) > MAX_BONES) ? BW'(MAX_BONES) : BW'(num_bones);
    assign dn = (phase_reg == PH_DONE) || (frame_reg >= num_frames);
    assign sts.done = dn;
    assign sts.ok   = ok;
    assign is_rot   = (phase_reg == PH_FIRST_ROT) || (phase_reg == PH_DELTA_ROT);
    assign idx      = AW'(bone_reg * 3 + axis_reg);

    // left align pending bits: oldest bit at the top
    assign al   = bits_reg << (PEND_W - cnt_reg);
    assign code = al[22:20];

    function automatic logic signed [16:0] sx(input logic [15:0] v, input logic [4:0] n);
        logic [15:0] m;
        m = v >> (16 - n);
        if (m[n-1]) return 17'(signed'({1'b0, m})) - (17'sd1 <<< n);
        return 17'(signed'({1'b0, m}));
    endfunction

    // decode one value from the head of the buffer
    always_comb
    begin
        ok  = 1'b0;
        len = '0;
        val = '0;
        case (phase_reg)
            PH_FIRST_OFS:
            begin
                ok  = cnt_reg >= 5'd16;
                len = 5'd16;
                val = sx(al[23:8], 5'd16);
            end
            PH_FIRST_ROT:
            begin
                ok  = cnt_reg >= 5'(w);
                len = 5'(w);
                val = sx(al[23:8], 5'(w)) <<< k;
            end
            PH_DELTA_OFS:
            begin
                len = al[23] ? 5'd17 : 5'd8;
                ok  = cnt_reg >= len && cnt_reg != 0;
                val = al[23] ? sx(al[22:7], 5'd16) : sx(al[22:7], 5'd7);
                if (axis_reg == 2'd1) val = -val;
            end
            PH_DELTA_ROT:
            begin
                if (!al[23])
                begin
                    ok  = cnt_reg >= 5'd1;
                    len = 5'd1;
                end
                else if (code == 3'd0)
                begin
                    len = 5'd4;
                    ok  = cnt_reg >= 5'd4;
                    val = -(17'sd1 <<< k);
                end
                else if (code != 3'd7)
                begin
                    len = 5'd4 + 5'(code);
                    ok  = cnt_reg >= 5'd4 && cnt_reg >= len;
                    val = sx(al[19:4], 5'(code));
                    val = (val < 0) ? val - (17'sd1 <<< (code - 3'd1))
                                    : val + (17'sd1 <<< (code - 3'd1));
                    val = val <<< k;
                end
                else
                begin
                    len = 5'd4 + 5'(w);
                    ok  = cnt_reg >= 5'd4 && cnt_reg >= len;
                    val = sx(al[19:4], 5'(w)) <<< k;
                end
            end
            default: ok = 1'b0;
        endcase
    end

    // accumulator update and report value
    assign acc_new = (phase_reg == PH_FIRST_ROT) ? val_reg[15:0] : acc_reg + val_reg[15:0];
    assign acc_s   = 17'(signed'(acc_new));

    // hold the decoded value and read the accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.try_dec)
        begin
            val_reg <= val;
            len_reg <= len;
        end
        if (cmd.acc_rd)
            acc_reg <= mem[idx];
        if (cmd.commit && is_rot)
            mem[idx] <= acc_new;
    end

    // output fields of the pending result
    always_comb
    begin
        o_kind  = is_rot;
        o_frame = frame_reg;
        o_bone  = is_rot ? BONE_W'(bone_reg) : '0;
        o_axis  = axis_reg;
        if (is_rot)
            o_value = acc_s[15] ? acc_s + 17'sd4096 : acc_s;
        else
            o_value = val_reg;
    end

    // position after this value, for the last flag
    logic [FRAME_W-1:0] frame_next;
    logic [BW-1:0]      bone_next;
    logic [1:0]         axis_next;
    phase_t             phase_next;
    always_comb
    begin
        frame_next = frame_reg;
        bone_next  = bone_reg;
        axis_next  = axis_reg + 2'd1;
        phase_next = phase_reg;
        if (axis_reg == 2'd2)
        begin
            axis_next = 2'd0;
            if (!is_rot && nb != 0)
            begin
                phase_next = phase_t'(phase_reg + 3'd1);
                bone_next  = '0;
            end
            else
            begin
                bone_next = bone_reg + 1'b1;
                if (!is_rot || bone_next >= nb)
                begin
                    frame_next = frame_reg + 1'b1;
                    bone_next  = '0;
                    phase_next = (frame_next >= num_frames || frame_next == 0) ? PH_DONE
                                                                              : PH_DELTA_OFS;
                end
            end
        end
    end
    assign o_last_anim = (phase_next == PH_DONE);

    // buffer and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            cnt_reg   <= '0;
            frame_reg <= '0;
            bone_reg  <= '0;
            axis_reg  <= '0;
            phase_reg <= PH_FIRST_OFS;
        end
        else
        begin
            if (cmd.clear)
            begin
                bits_reg  <= '0;
                cnt_reg   <= '0;
                frame_reg <= '0;
                bone_reg  <= '0;
                axis_reg  <= '0;
                phase_reg <= PH_FIRST_OFS;
            end
            else if (cmd.drop)
            begin
                bits_reg  <= '0;
                cnt_reg   <= '0;
                phase_reg <= PH_DONE;
            end
            else if (cmd.load)
            begin
                bits_reg <= {bits_reg[15:0], data_byte};
                cnt_reg  <= ((cnt_reg > 5'd16) ? 5'd16 : cnt_reg) + 5'd8;
            end
            else if (cmd.commit)
            begin
                cnt_reg   <= cnt_reg - len_reg;
                bits_reg  <= bits_reg & ((PEND_W'(1) << (cnt_reg - len_reg)) - 1'b1);
                frame_reg <= frame_next;
                bone_reg  <= bone_next;
                axis_reg  <= axis_next;
                phase_reg <= phase_next;
            end
        end
    end

endmodule

[rtl/animation_delta_bitstream_decoder.sv]
// ---------------------------------------------------------------------------
// animation_delta_bitstream_decoder
// Decodes a skeletal animation frame bitstream into offsets and rotations.
// ---------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata[7:0]=data_byte, tuser=command
//  m_axis    out  tdata=frame,bone,axis,value; tuser=kind,last_of_animation;
//                 tlast=last_of_run
//  cfg       in   cfg_we, cfg_index, cfg_data
// A data byte is accepted, then each of its n decoded values (n at most eight)
// passes the steps try, read accumulator and hand out, and a final try ends
// the byte. Begin and dropped requests finish in the accept step.
// Reset clears position and buffer; accumulators are undefined until written.
// A stalled output holds the sequencer in its hand-out step, and a new request
// waits until the last result of the previous byte reaches the output register.
module animation_delta_bitstream_decoder #(
    parameter int MAX_BONES = adbd_pkg::MAX_BONES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // frame_index, bone_index, axis, decoded_value
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // value_kind, last_of_animation
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import adbd_pkg::*;

    logic [6:0]  num_bones_reg;
    logic [15:0] num_frames_reg;
    logic [3:0]  key_reg;
    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic        ctrl_idle;
    logic        o_kind, o_last;
    logic [15:0] o_frame;
    logic [5:0]  o_bone;
    logic [1:0]  o_axis;
    logic [16:0] o_value;
    logic        emit;
    logic        slot_free;
    logic        xfer;
    logic        sv_reg, sv_next;
    logic [47:0] sd_reg;
    logic [1:0]  su_reg;
    logic        sl_reg, sl_next;
    logic        pend_reg, pend_next;
    logic [47:0] hd_reg;
    logic [1:0]  hu_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bones_reg  <= '0;
            num_frames_reg <= '0;
            key_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BONES:    num_bones_reg  <= cfg_data[6:0];
                REG_FRAMES:   num_frames_reg <= cfg_data;
                REG_PREC_KEY: key_reg        <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    adbd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_cmd(s_axis_tuser), .in_ready(s_axis_tready),
        .in_hold(pend_reg), .res_free(!pend_reg || slot_free),
        .cmd(cmd), .sts(sts), .idle(ctrl_idle)
    );

    adbd_dp #(.MAX_BONES(MAX_BONES)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .num_bones(num_bones_reg), .num_frames(num_frames_reg),
        .precision_key(key_reg), .data_byte(s_axis_tdata),
        .cmd(cmd), .sts(sts),
        .o_kind(o_kind), .o_frame(o_frame), .o_bone(o_bone), .o_axis(o_axis),
        .o_value(o_value), .o_last_anim(o_last)
    );

    assign emit      = cmd.commit;
    assign slot_free = !sv_reg || m_axis_tready;
    assign xfer      = pend_reg && slot_free && (emit || ctrl_idle);

    // one result held back until the next value or end of byte decides tlast
    always_comb
    begin
        sv_next   = sv_reg;
        sl_next   = sl_reg;
        pend_next = pend_reg;
        if (sv_reg && m_axis_tready)
            sv_next = 1'b0;
        if (xfer)
        begin
            sv_next   = 1'b1;
            sl_next   = !emit;
            pend_next = 1'b0;
        end
        if (emit)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            sv_reg   <= 1'b0;
            sl_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            sv_reg   <= sv_next;
            sl_reg   <= sl_next;
        end
    end

    // held result and output register contents
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            hd_reg <= {7'd0, o_value, o_axis, o_bone, o_frame};
            hu_reg <= {o_last, o_kind};
        end
        if (xfer)
        begin
            sd_reg <= hd_reg;
            su_reg <= hu_reg;
        end
    end

    assign m_axis_tvalid = sv_reg;
    assign m_axis_tdata  = sd_reg;
    assign m_axis_tuser  = su_reg;
    assign m_axis_tlast  = sl_reg;

endmodule
